// ===== src/sgsa_pkg.sv =====
`timescale 1ns / 1ps

package sgsa_pkg;

    // Fixed field widths
    localparam int GLYPH_W = 13;
    localparam int ADDR_W  = 32;
    localparam int CB_W    = 2;
    localparam int FONT_W  = 8;
    localparam int TPL_W   = 32;
    localparam int SLOT_W  = 8;
    localparam int TILE_W  = 10;
    localparam int KEY_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top-level parameters
    localparam int SLOT_COUNT_DEF  = 224;
    localparam int GLYPH_LIMIT_DEF = 7168;

    // Register reset values
    localparam logic [TILE_W-1:0] POOL_BASE_RESET  = 10'd521;
    localparam logic [FONT_W-1:0] SMALL_FONT_RESET = 8'd4;

    // Video memory window for tile data
    localparam logic [ADDR_W-1:0] VRAM_LOW  = 32'h0600_0000;
    localparam logic [ADDR_W-1:0] VRAM_HIGH = 32'h0601_8000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_FONT = 2'd1;

    typedef enum logic [1:0] {
        STATUS_HIT     = 2'd0,
        STATUS_NEW     = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

    // Search token that walks the cell chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } token_t;

    // Broadcast table write
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } table_wr_t;

endpackage

// ===== src/sgsa_cell.sv =====
`timescale 1ns / 1ps

module sgsa_cell
    import sgsa_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  token_t            tok_in,
    input  table_wr_t         wr,
    input  logic [SLOT_W-1:0] count,
    output token_t            tok_out
);

    localparam logic [SLOT_W-1:0] IDX_L = SLOT_W'(IDX);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             tok_valid_reg;
    logic             tok_valid_next;
    token_t           tok_reg;
    token_t           tok_next;
    logic             match;

    // Entry counts only while it lies below the fill count
    assign match = (IDX_L < count) && (entry_reg == tok_in.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (wr.en && (wr.slot == IDX_L))
        begin
            entry_next = wr.key;
        end
    end

    always_comb
    begin
        tok_valid_next = tok_in.valid;
        tok_next       = tok_in;
        tok_next.hit   = tok_in.hit | match;
        tok_next.slot  = tok_in.hit ? tok_in.slot : IDX_L;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tok_reg   <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

// ===== src/sticky_glyph_slot_allocator.sv =====
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// -------  ----------------------  -----------------------------------------------
// in       in_valid / in_ready     glyph_code, tile_data_addr, fallback_char_base,
//                                  font_number, screen_template
// out      out_valid / out_ready   status, slot, top_tile, dest_addr, char_base
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// For each item the search token walks the chain of key cells (the first cell loads on
// the accept edge), the search outcome is captured at the chain end, and the item is
// then resolved into the registered outputs. Every item walks all cells.
// Reset clears the fill count, the screen signature and the registers to defaults;
// key cells are not cleared, since only entries below the fill count are compared.
// A result waiting on out_ready holds only the resolve step; a new item is accepted
// as soon as the block is back in idle.

module sticky_glyph_slot_allocator
    import sgsa_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int GLYPH_LIMIT = GLYPH_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [GLYPH_W-1:0]    glyph_code,
    input  logic [ADDR_W-1:0]     tile_data_addr,
    input  logic [CB_W-1:0]       fallback_char_base,
    input  logic [FONT_W-1:0]     font_number,
    input  logic [TPL_W-1:0]      screen_template,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [SLOT_W-1:0]     slot,
    output logic [TILE_W-1:0]     top_tile,
    output logic [ADDR_W-1:0]     dest_addr,
    output logic [CB_W-1:0]       char_base,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [SLOT_W-1:0]  SLOT_CNT_L  = SLOT_W'(SLOT_COUNT);
    localparam logic [GLYPH_W:0]   GLYPH_LIM_L = (GLYPH_W+1)'(GLYPH_LIMIT);

    // ---------------------------------------------------------------
    // State and registers
    // ---------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic [TILE_W-1:0] pool_base_reg;
    logic [TILE_W-1:0] pool_base_next;
    logic [FONT_W-1:0] small_font_reg;
    logic [FONT_W-1:0] small_font_next;

    logic [SLOT_W-1:0] count_reg;
    logic [SLOT_W-1:0] count_next;
    logic [TPL_W-1:0]  last_tpl_reg;
    logic [TPL_W-1:0]  last_tpl_next;
    logic [CB_W-1:0]   last_cb_reg;
    logic [CB_W-1:0]   last_cb_next;

    // Item under work
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [CB_W-1:0]   cb_reg;
    logic [CB_W-1:0]   cb_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [TPL_W-1:0]  tpl_reg;
    logic [TPL_W-1:0]  tpl_next;
    logic              invalid_reg;
    logic              invalid_next;

    // Search outcome captured at the chain end
    logic              hit_reg;
    logic              hit_next;
    logic [SLOT_W-1:0] hit_slot_reg;
    logic [SLOT_W-1:0] hit_slot_next;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [TILE_W-1:0] top_tile_reg;
    logic [TILE_W-1:0] top_tile_next;
    logic [ADDR_W-1:0] dest_addr_reg;
    logic [ADDR_W-1:0] dest_addr_next;
    logic [CB_W-1:0]   char_base_reg;
    logic [CB_W-1:0]   char_base_next;

    // Control strobes for the handshakes and the chain end
    logic accept;
    logic finish;
    logic chain_done;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    token_t    tok [SLOT_COUNT+1];
    table_wr_t wr;

    // Inject the key straight from the input at the accept edge
    assign tok[0] = {accept, 1'b0, {SLOT_W{1'b0}}, key_next};

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++)
        begin : g_cell
            sgsa_cell #(
                .IDX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[gi]),
                .wr      (wr),
                .count   (count_reg),
                .tok_out (tok[gi+1])
            );
        end
    endgenerate

    assign chain_done = tok[SLOT_COUNT].valid;

    // ---------------------------------------------------------------
    // Request decode: resolve base address, char base and key
    // ---------------------------------------------------------------
    logic in_vram;
    logic small_font;

    always_comb
    begin
        in_vram      = (tile_data_addr >= VRAM_LOW) && (tile_data_addr < VRAM_HIGH);
        base_next    = in_vram ? tile_data_addr
                               : (VRAM_LOW | {16'b0, fallback_char_base, 14'b0});
        cb_next      = base_next[15:14];
        small_font   = (font_number == small_font_reg);
        key_next     = {small_font, cb_next, glyph_code};
        tpl_next     = screen_template;
        invalid_next = ({1'b0, glyph_code} >= GLYPH_LIM_L);
    end

    // ---------------------------------------------------------------
    // FSM: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // FSM: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                in_ready = 1'b0;
            end
            ST_RESOLVE:
            begin
                finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // ---------------------------------------------------------------
    // Resolve: hit, append, restart or refuse
    // ---------------------------------------------------------------
    logic              full;
    logic              sig_changed;
    logic [SLOT_W-1:0] res_slot;
    logic [TILE_W-1:0] top_calc;
    logic [ADDR_W-1:0] dest_calc;
    logic              do_write;

    always_comb
    begin
        full        = (count_reg >= SLOT_CNT_L);
        sig_changed = (tpl_reg != last_tpl_reg) || (cb_reg != last_cb_reg);
        res_slot    = hit_reg ? hit_slot_reg : (full ? '0 : count_reg);
        top_calc    = pool_base_reg + {1'b0, res_slot, 1'b0};
        dest_calc   = base_reg + {17'b0, top_calc, 5'b0};
        do_write    = 1'b0;

        status_next    = status_reg;
        slot_next      = slot_reg;
        top_tile_next  = top_tile_reg;
        dest_addr_next = dest_addr_reg;
        char_base_next = char_base_reg;

        if (finish)
        begin
            if (invalid_reg)
            begin
                status_next    = STATUS_INVALID;
                slot_next      = '0;
                top_tile_next  = '0;
                dest_addr_next = '0;
                char_base_next = '0;
            end
            else if (hit_reg)
            begin
                status_next    = STATUS_HIT;
                slot_next      = res_slot;
                top_tile_next  = top_calc;
                dest_addr_next = dest_calc;
                char_base_next = cb_reg;
            end
            else if (full && !sig_changed)
            begin
                status_next    = STATUS_FULL;
                slot_next      = '0;
                top_tile_next  = '0;
                dest_addr_next = '0;
                char_base_next = cb_reg;
            end
            else
            begin
                // Append, or restart at slot 0 on a full table
                do_write       = 1'b1;
                status_next    = STATUS_NEW;
                slot_next      = res_slot;
                top_tile_next  = top_calc;
                dest_addr_next = dest_calc;
                char_base_next = cb_reg;
            end
        end
    end

    always_comb
    begin
        wr.en   = do_write;
        wr.slot = res_slot;
        wr.key  = key_reg;
    end

    always_comb
    begin
        count_next    = count_reg;
        last_tpl_next = last_tpl_reg;
        last_cb_next  = last_cb_reg;
        if (do_write)
        begin
            count_next    = res_slot + SLOT_W'(1);
            last_tpl_next = tpl_reg;
            last_cb_next  = cb_reg;
        end
    end

    // Capture the token leaving the last cell
    always_comb
    begin
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        if (chain_done)
        begin
            hit_next      = tok[SLOT_COUNT].hit;
            hit_slot_next = tok[SLOT_COUNT].slot;
        end
    end

    // Hold the output item until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration writes; unknown indexes drop
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pool_base_next  = pool_base_reg;
        small_font_next = small_font_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:  pool_base_next  = cfg_data[TILE_W-1:0];
                CFG_SMALL_FONT: small_font_next = cfg_data[FONT_W-1:0];
                default:
                begin
                    pool_base_next  = pool_base_reg;
                    small_font_next = small_font_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pool_base_reg  <= POOL_BASE_RESET;
            small_font_reg <= SMALL_FONT_RESET;
            count_reg      <= '0;
            last_tpl_reg   <= '0;
            last_cb_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pool_base_reg  <= pool_base_next;
            small_font_reg <= small_font_next;
            count_reg      <= count_next;
            last_tpl_reg   <= last_tpl_next;
            last_cb_reg    <= last_cb_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg    <= base_next;
            cb_reg      <= cb_next;
            key_reg     <= key_next;
            tpl_reg     <= tpl_next;
            invalid_reg <= invalid_next;
        end
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        top_tile_reg  <= top_tile_next;
        dest_addr_reg <= dest_addr_next;
        char_base_reg <= char_base_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign top_tile  = top_tile_reg;
    assign dest_addr = dest_addr_reg;
    assign char_base = char_base_reg;

endmodule
